// File: src/ascii85_line_wrapped_encoder_defines.svh
// ----------------------------------------------------------------------------
// ascii85 line wrapped encoder assertion macros
// shared same-cycle and next-cycle implication checks on clk and rst_n
// ----------------------------------------------------------------------------
`ifndef ASCII85_LINE_WRAPPED_ENCODER_DEFINES_SVH
`define ASCII85_LINE_WRAPPED_ENCODER_DEFINES_SVH

// same-cycle implication
`define A85LW_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("a85lw check failed");

// next-cycle implication
`define A85LW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("a85lw check failed");

`endif

// File: src/a85lw_pkg.sv
// ----------------------------------------------------------------------------
// a85lw_pkg
// types and constants shared by the ascii85 line wrapped encoder
// ----------------------------------------------------------------------------
package a85lw_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic        finish;
    logic        zero;
    logic [2:0]  used;
    logic [31:0] value;
  } job_t;

  typedef struct packed {
    logic            finish;
    logic            zero;
    logic [2:0]      used;
    logic [4:0][6:0] dig;
  } grp_t;

  localparam logic [7:0]  LINE_WIDTH_RESET = 8'd75;
  localparam logic [7:0]  MIN_WIDTH        = 8'd4;
  localparam logic [7:0]  CHAR_NL          = 8'd10;
  localparam logic [7:0]  CHAR_Z           = 8'd122;
  localparam logic [7:0]  CHAR_TILDE       = 8'd126;
  localparam logic [7:0]  CHAR_GT          = 8'd62;
  localparam logic [7:0]  DIGIT_BASE       = 8'd33;
  localparam logic [6:0]  RADIX            = 7'd85;
  localparam logic [31:0] RECIP_85         = 32'd3233857729;
  localparam int          RECIP_SHIFT      = 38;
  localparam logic [2:0]  FULL_GROUP       = 3'd4;
  localparam logic [2:0]  DIGITS_FULL      = 3'd5;

endpackage

// File: src/ascii85_line_wrapped_encoder.sv
// ----------------------------------------------------------------------------
// ascii85_line_wrapped_encoder
// byte stream to ascii85 text with line wrapping and end-of-data marker
//
//   channel | ports                          | moves
//   --------+--------------------------------+------------------------------
//   input   | in_valid, in_ready, in_data    | one byte or finish per transfer
//   output  | out_valid, out_ready, out_data | one character per transfer
//   config  | cfg_we, cfg_wdata              | line width, single cycle write
//
// the digit unit takes four remainder steps per four-byte group, with a
// reciprocal multiply step between each, and takes a new job only as it
// finishes the last one; characters leave at one per cycle unless out_ready
// stalls them; a job queue lets bytes enter while the digit unit or the output is stalled
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module ascii85_line_wrapped_encoder import a85lw_pkg::*; #(
  parameter int JOB_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] width_r;
  logic [7:0] width_eff;

  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;
  logic grp_valid, grp_ready;
  grp_t grp_data;

  assign width_eff = (width_r < MIN_WIDTH) ? MIN_WIDTH : width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  a85lw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_push (job_push),
    .job_data (job_in),
    .job_full (job_full)
  );

  a85lw_fifo #(.DEPTH(JOB_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  logic job_ready;
  assign job_pop = job_ready && !job_empty;

  a85lw_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job_ready (job_ready),
    .job_data  (job_out),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp_data  (grp_data)
  );

  a85lw_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp_data  (grp_data),
    .width_i   (width_eff),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/a85lw_front.sv
// ----------------------------------------------------------------------------
// a85lw_front
// gathers input bytes into groups and queues encode jobs
// ----------------------------------------------------------------------------
module a85lw_front import a85lw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic job_push,
  output job_t job_data,
  input  logic job_full
);

  logic [23:0] group_r, group_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        accept;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    group_nxt = group_r;
    count_nxt = count_r;
    job_push  = 1'b0;
    job_data  = '0;
    if (accept) begin
      if (in_data.kind) begin
        job_push        = 1'b1;
        job_data.finish = 1'b1;
        job_data.used   = {1'b0, count_r};
        case (count_r)
          2'd1:    job_data.value = {group_r[7:0], 24'h0};
          2'd2:    job_data.value = {group_r[15:0], 16'h0};
          2'd3:    job_data.value = {group_r, 8'h0};
          default: job_data.value = '0;
        endcase
        group_nxt = '0;
        count_nxt = '0;
      end else if (count_r == 2'd3) begin
        job_push       = 1'b1;
        job_data.used  = FULL_GROUP;
        job_data.value = {group_r, in_data.data_byte};
        group_nxt      = '0;
        count_nxt      = '0;
      end else begin
        group_nxt = {group_r[15:0], in_data.data_byte};
        count_nxt = count_r + 2'd1;
      end
    end
    job_data.zero = (job_data.used == FULL_GROUP) && (job_data.value == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
      count_r <= '0;
    end else begin
      group_r <= group_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: src/a85lw_fifo.sv
// ----------------------------------------------------------------------------
// a85lw_fifo
// short job queue between the byte front end and the digit back end
// ----------------------------------------------------------------------------
`include "ascii85_line_wrapped_encoder_defines.svh"

module a85lw_fifo import a85lw_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `A85LW_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))

endmodule

// File: src/a85lw_conv.sv
// ----------------------------------------------------------------------------
// a85lw_conv
// splits a 32-bit group into five base-85 digits, reciprocal multiply per remainder step
// ----------------------------------------------------------------------------
`include "ascii85_line_wrapped_encoder_defines.svh"

module a85lw_conv import a85lw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job_data,
  output logic grp_valid,
  input  logic grp_ready,
  output grp_t grp_data
);

  typedef enum logic [1:0] {CV_IDLE, CV_MUL, CV_SUB} cv_state_t;

  cv_state_t       state_r;
  logic [1:0]      step_r;
  logic [31:0]     cur_r;
  logic [63:0]     prod_r;
  logic [4:0][6:0] dig_r;
  logic            finish_r, zero_r;
  logic [2:0]      used_r;
  logic            out_valid_r;
  grp_t            out_r;

  logic [25:0]     quo;
  logic [31:0]     rem32;
  logic            last_step, out_free, load;
  grp_t            done_grp;

  assign quo       = prod_r[63:RECIP_SHIFT];
  assign rem32     = cur_r - ({6'd0, quo} * {25'd0, RADIX});
  assign last_step = (state_r == CV_SUB) && (step_r == 2'd3);
  assign out_free  = !out_valid_r || grp_ready;
  assign job_ready = (state_r == CV_IDLE) || (last_step && out_free);
  assign load      = job_valid && job_ready;
  assign grp_valid = out_valid_r;
  assign grp_data  = out_r;

  always_comb begin
    done_grp        = '0;
    done_grp.finish = finish_r;
    done_grp.zero   = zero_r;
    done_grp.used   = used_r;
    done_grp.dig    = dig_r;
    done_grp.dig[1] = rem32[6:0];
    done_grp.dig[0] = quo[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CV_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && grp_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        CV_IDLE: begin
          state_r <= CV_IDLE;
        end
        CV_MUL: begin
          prod_r  <= cur_r * RECIP_85;
          state_r <= CV_SUB;
        end
        CV_SUB: begin
          if (!last_step) begin
            dig_r[3'd4 - {1'b0, step_r}] <= rem32[6:0];
            cur_r   <= {6'd0, quo};
            step_r  <= step_r + 2'd1;
            state_r <= CV_MUL;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            out_r       <= done_grp;
            state_r     <= CV_IDLE;
          end
        end
        default: state_r <= CV_IDLE;
      endcase
      if (load) begin
        prod_r   <= job_data.value * RECIP_85;
        cur_r    <= job_data.value;
        finish_r <= job_data.finish;
        zero_r   <= job_data.zero;
        used_r   <= job_data.used;
        step_r   <= '0;
        state_r  <= CV_SUB;
      end
    end
  end

  `A85LW_ASSERT_NOW(a_rem_range, state_r == CV_SUB, rem32 < {25'd0, RADIX})
  `A85LW_ASSERT_NOW(a_quo_range, last_step, quo < {19'd0, RADIX})

endmodule

// File: src/a85lw_emit.sv
// ----------------------------------------------------------------------------
// a85lw_emit
// sends digits one character a cycle unless out_ready stalls, wraps lines and closes the stream
// ----------------------------------------------------------------------------
`include "ascii85_line_wrapped_encoder_defines.svh"

module a85lw_emit import a85lw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_valid,
  output logic       grp_ready,
  input  grp_t       grp_data,
  input  logic [7:0] width_i,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  typedef enum logic [2:0] {
    EM_IDLE, EM_DIG, EM_PRE_NL, EM_TILDE, EM_GT, EM_END_NL
  } em_state_t;

  em_state_t  state_r, state_nxt;
  grp_t       grp_r;
  logic [2:0] ndig_r, ndig_in;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] col_r, col_nxt;
  logic       out_valid_r;
  out_t       out_r;

  logic       adv, wrap, last_dig, load, emit_en, emit_last;
  logic [7:0] dig_char, emit_char;

  assign adv      = !out_valid_r || out_ready;
  assign wrap     = col_r >= width_i;
  assign last_dig = idx_r == (ndig_r - 3'd1);
  assign dig_char = grp_r.zero ? CHAR_Z : ({1'b0, grp_r.dig[idx_r]} + DIGIT_BASE);
  assign grp_ready = (state_r == EM_IDLE) ||
                     ((state_r == EM_DIG) && adv && !wrap && last_dig && !grp_r.finish);
  assign load      = grp_valid && grp_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (grp_data.zero) begin
      ndig_in = 3'd1;
    end else if (grp_data.finish) begin
      ndig_in = (grp_data.used == '0) ? 3'd0 : grp_data.used + 3'd1;
    end else begin
      ndig_in = DIGITS_FULL;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    col_nxt   = col_r;
    emit_en   = 1'b0;
    emit_char = CHAR_NL;
    emit_last = 1'b0;
    case (state_r)
      EM_IDLE: begin
        state_nxt = EM_IDLE;
      end
      EM_DIG: begin
        if (adv) begin
          emit_en = 1'b1;
          if (wrap) begin
            col_nxt = '0;
          end else begin
            emit_char = dig_char;
            col_nxt   = col_r + 8'd1;
            idx_nxt   = idx_r + 3'd1;
            if (last_dig) begin
              if (grp_r.finish) begin
                state_nxt = EM_PRE_NL;
              end else begin
                emit_last = 1'b1;
                state_nxt = EM_IDLE;
              end
            end
          end
        end
      end
      EM_PRE_NL: begin
        if (adv) begin
          emit_en   = 1'b1;
          col_nxt   = '0;
          state_nxt = EM_TILDE;
        end
      end
      EM_TILDE: begin
        if (adv) begin
          emit_en   = 1'b1;
          emit_char = CHAR_TILDE;
          state_nxt = EM_GT;
        end
      end
      EM_GT: begin
        if (adv) begin
          emit_en   = 1'b1;
          emit_char = CHAR_GT;
          state_nxt = EM_END_NL;
        end
      end
      EM_END_NL: begin
        if (adv) begin
          emit_en   = 1'b1;
          emit_last = 1'b1;
          col_nxt   = '0;
          state_nxt = EM_IDLE;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
    if (load) begin
      idx_nxt = '0;
      if (ndig_in != '0) begin
        state_nxt = EM_DIG;
      end else if (col_nxt != '0) begin
        state_nxt = EM_PRE_NL;
      end else begin
        state_nxt = EM_TILDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      idx_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      col_r   <= col_nxt;
      if (emit_en) begin
        out_valid_r     <= 1'b1;
        out_r.out_char  <= emit_char;
        out_r.last_char <= emit_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        grp_r  <= grp_data;
        ndig_r <= ndig_in;
      end
    end
  end

  `A85LW_ASSERT_NOW(a_trailer_col, state_r == EM_TILDE, col_r == '0)

endmodule

// File: bench/ascii85_line_wrapped_encoder_tb.sv
// ----------------------------------------------------------------------------
// ascii85_line_wrapped_encoder_tb
// drives bytes and finish items into the ascii85 encoder with random gaps and
// output stalls, predicts the encoded text with line wrapping and end marker,
// and compares every output character and its last flag in order
// ----------------------------------------------------------------------------
module ascii85_line_wrapped_encoder_tb;
  import a85lw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_FINISH  = 1'b1;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   CYCLE_LIMIT   = 300000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  // encoder shadow state
  logic [7:0]  width_reg;
  logic [23:0] held_bytes;
  logic [1:0]  held_count;
  logic [7:0]  column;
  logic [7:0]  item_chars[$];
  out_t        expected_chars[$];

  int   error_count;
  int   cycle_count;
  bit   gaps_on;
  bit   stalls_on;
  bit   out_fire;
  out_t out_seen;
  out_t want;

  ascii85_line_wrapped_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic void put_wrapped(input logic [7:0] c);
    logic [7:0] w;
    w = (width_reg < MIN_WIDTH) ? MIN_WIDTH : width_reg;
    if (column >= w) begin
      item_chars.push_back(CHAR_NL);
      column = 8'd0;
    end
    item_chars.push_back(c);
    column = column + 8'd1;
  endfunction

  function automatic void encode_group(input logic [31:0] value, input int used);
    logic [7:0]  digits[5];
    logic [31:0] v;
    if (used == 4 && value == 32'd0) begin
      put_wrapped(CHAR_Z);
    end else begin
      v = value;
      for (int i = 4; i >= 0; i--) begin
        digits[i] = 8'(v % 32'd85) + DIGIT_BASE;
        v = v / 32'd85;
      end
      for (int i = 0; i <= used && i < 5; i++) begin
        put_wrapped(digits[i]);
      end
    end
  endfunction

  function automatic void predict_item(input in_t item);
    logic [31:0] value;
    int          shift;
    item_chars.delete();
    if (item.kind == KIND_DATA) begin
      if (held_count == 2'd3) begin
        value = {held_bytes, item.data_byte};
        encode_group(value, 4);
        held_bytes = '0;
        held_count = '0;
      end else begin
        held_bytes = {held_bytes[15:0], item.data_byte};
        held_count = held_count + 2'd1;
      end
    end else begin
      if (held_count != 2'd0) begin
        shift = 8 * (4 - int'(held_count));
        value = {8'h00, held_bytes} << shift;
        encode_group(value, int'(held_count));
      end
      if (column != 8'd0) begin
        item_chars.push_back(CHAR_NL);
      end
      item_chars.push_back(CHAR_TILDE);
      item_chars.push_back(CHAR_GT);
      item_chars.push_back(CHAR_NL);
      held_bytes = '0;
      held_count = '0;
      column     = '0;
    end
    foreach (item_chars[i]) begin
      expected_chars.push_back('{out_char: item_chars[i],
                                 last_char: (i == item_chars.size() - 1)});
    end
  endfunction

  task automatic send_item(input in_t item);
    bit taken;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      if (taken) begin
        predict_item(item);
      end
      @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item('{kind: KIND_DATA, data_byte: b});
  endtask

  task automatic send_finish();
    send_item('{kind: KIND_FINISH, data_byte: 8'($urandom_range(0, 255))});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [7:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    width_reg = w;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: rand_byte = 8'h00;
      1: rand_byte = 8'hff;
      default: rand_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // zero group, all-ones group, mixed group, then finish on a nonempty line
  task automatic test_full_groups();
    repeat (4) send_byte(8'h00);
    repeat (4) send_byte(8'hff);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h04);
    send_finish();
  endtask

  // finish with nothing held and the column at zero
  task automatic test_empty_finish();
    send_finish();
  endtask

  // one, two and three byte tails, a zero tail must not become z
  task automatic test_partial_groups();
    send_byte(8'h00);
    send_finish();
    send_byte(8'hff);
    send_byte(8'hff);
    send_finish();
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'h55);
    send_finish();
  endtask

  task automatic run_random_phase(input int n_items, input bit close_stream);
    int sent;
    int nbytes;
    bit zero_group;
    sent = 0;
    while (sent < n_items) begin
      zero_group = ($urandom_range(0, 4) == 0);
      nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
      for (int i = 0; i < nbytes; i++) begin
        send_byte(zero_group ? 8'h00 : rand_byte());
        sent++;
      end
      if (nbytes < 4 || $urandom_range(0, 9) == 0) begin
        send_finish();
        sent++;
      end
    end
    if (close_stream) begin
      send_finish();
    end
  endtask

  // width changes between phases, some of them mid-line
  task automatic test_random_widths();
    logic [7:0] widths[10];
    widths = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd9, 8'd255,
               8'($urandom_range(1, 255)), 8'($urandom_range(4, 20)), 8'd75};
    foreach (widths[i]) begin
      wait_idle();
      write_width(widths[i]);
      run_random_phase(20, (i % 2) == 0);
    end
  endtask

  // back to back transfers with no gaps or stalls
  task automatic test_steady_stream();
    wait_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_width(LINE_WIDTH_RESET);
    run_random_phase(20, 1'b1);
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    out_fire = rst_n && out_valid && out_ready;
    out_seen = out_data;
  end

  always @(posedge clk) begin
    if (out_fire) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %0d", out_seen.out_char));
      end else begin
        want = expected_chars.pop_front();
        if (out_seen.out_char !== want.out_char) begin
          report_mismatch($sformatf("out_char got %0d want %0d",
                                    out_seen.out_char, want.out_char));
        end
        if (out_seen.last_char !== want.last_char) begin
          report_mismatch($sformatf("last_char got %0b want %0b on char %0d",
                                    out_seen.last_char, want.last_char,
                                    want.out_char));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      report_mismatch("timeout");
      $display("ascii85_line_wrapped_encoder_tb: FAIL");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    out_fire    = 1'b0;
    width_reg   = LINE_WIDTH_RESET;
    held_bytes  = '0;
    held_count  = '0;
    column      = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_groups();
    test_empty_finish();
    test_partial_groups();
    test_random_widths();
    test_steady_stream();

    wait_idle();
    if (error_count == 0) begin
      $display("ascii85_line_wrapped_encoder_tb: PASS");
    end else begin
      $display("ascii85_line_wrapped_encoder_tb: FAIL");
    end
    $finish;
  end

endmodule
